FILE: rtl/core/aa_pkg.sv
// Package for the arrive steering accelerator.
// Holds field widths, the default fraction width and the register index codes.
// No dependencies.
package aa_pkg;

    localparam int AA_FRAC_BITS = 16;
    localparam int AA_DATA_W    = 32;
    localparam int AA_REG_W     = 31;
    localparam int AA_IDX_W     = 3;

    typedef enum logic [AA_IDX_W-1:0] {
        REG_ARRIVE_RADIUS,
        REG_DEST_RADIUS,
        REG_MAX_SPEED,
        REG_MAX_DECEL,
        REG_WEIGHT
    } aa_reg_t;

endpackage

FILE: rtl/core/aa_if.sv
// Channel interfaces of the arrive steering accelerator: input item and result.
// Depends on aa_pkg for the field widths.
interface aa_item_if import aa_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [AA_DATA_W-1:0] target_x;
    logic signed [AA_DATA_W-1:0] target_y;
    logic signed [AA_DATA_W-1:0] pos_x;
    logic signed [AA_DATA_W-1:0] pos_y;
    logic signed [AA_DATA_W-1:0] vel_x;
    logic signed [AA_DATA_W-1:0] vel_y;

    modport source (output valid, target_x, target_y, pos_x, pos_y, vel_x, vel_y,
                    input ready);
    modport sink (input valid, target_x, target_y, pos_x, pos_y, vel_x, vel_y,
                  output ready);
endinterface

interface aa_result_if import aa_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [AA_DATA_W-1:0] accel_x;
    logic signed [AA_DATA_W-1:0] accel_y;
    logic                        accel_valid;
    logic                        stop_velocity;
    logic                        arriving;

    modport source (output valid, accel_x, accel_y, accel_valid, stop_velocity, arriving,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_valid, stop_velocity, arriving,
                  output ready);
endinterface

FILE: rtl/core/aa_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Carries an opaque sideband alongside; no package dependencies.
module aa_sqrt_pipe #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_n,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [IN_W/2-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STEPS = IN_W / 2;

    logic [IN_W-1:0]   n_reg    [STEPS];
    logic [IN_W-1:0]   r_reg    [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic              v_reg    [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int SH = 2 * (STEPS - 1 - k);
        localparam logic [IN_W-1:0] BIT_C = {{(IN_W-1){1'b0}}, 1'b1} << SH;

        logic [IN_W-1:0]   n_p;
        logic [IN_W-1:0]   r_p;
        logic [SIDE_W-1:0] side_p;
        logic              v_p;
        logic [IN_W-1:0]   trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign n_p    = in_n;
            assign r_p    = '0;
            assign side_p = in_side;
            assign v_p    = in_valid;
        end
        else begin : g_next
            assign n_p    = n_reg[k-1];
            assign r_p    = r_reg[k-1];
            assign side_p = side_reg[k-1];
            assign v_p    = v_reg[k-1];
        end

        assign trial = r_p + BIT_C;
        assign ge    = (n_p >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= ge ? (n_p - trial) : n_p;
                r_reg[k]    <= ge ? ((r_p >> 1) + BIT_C) : (r_p >> 1);
                side_reg[k] <= side_p;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_p;
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_root  = r_reg[STEPS-1][IN_W/2-1:0];
    assign out_side  = side_reg[STEPS-1];

endmodule

FILE: rtl/core/aa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage, with
// several dividend lanes over one divisor. No package dependencies.
module aa_div_pipe #(
    parameter int LANES  = 1,
    parameter int N_W    = 62,
    parameter int D_W    = 32,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][N_W-1:0]   in_dvd,
    input  logic [D_W-1:0]              in_div,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W-1:0]   out_quo,
    output logic [SIDE_W-1:0]           out_side
);

    // The quotient must fit in Q_W bits, so the top dividend bits start
    // out below the divisor.
    logic [LANES-1:0][D_W-1:0] rem_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0] low_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0] quo_reg  [Q_W];
    logic [D_W-1:0]            dv_reg   [Q_W];
    logic [SIDE_W-1:0]         side_reg [Q_W];
    logic                      v_reg    [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [LANES-1:0][D_W-1:0] rem_p;
        logic [LANES-1:0][Q_W-1:0] low_p;
        logic [LANES-1:0][Q_W-1:0] quo_p;
        logic [D_W-1:0]            dv_p;
        logic [SIDE_W-1:0]         side_p;
        logic                      v_p;
        logic [LANES-1:0][D_W-1:0] rem_next;
        logic [LANES-1:0][Q_W-1:0] quo_next;

        if (k == 0) begin : g_first
            for (genvar j = 0; j < LANES; j++) begin : g_lane
                assign rem_p[j] = D_W'(in_dvd[j][N_W-1:Q_W]);
                assign low_p[j] = in_dvd[j][Q_W-1:0];
                assign quo_p[j] = '0;
            end
            assign dv_p   = in_div;
            assign side_p = in_side;
            assign v_p    = in_valid;
        end
        else begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign low_p  = low_reg[k-1];
            assign quo_p  = quo_reg[k-1];
            assign dv_p   = dv_reg[k-1];
            assign side_p = side_reg[k-1];
            assign v_p    = v_reg[k-1];
        end

        always_comb
        begin
            logic [D_W:0] trial;
            logic [D_W:0] diff;
            for (int j = 0; j < LANES; j++)
            begin
                trial = {rem_p[j], low_p[j][Q_W-1]};
                diff  = trial - {1'b0, dv_p};
                if (trial >= {1'b0, dv_p})
                begin
                    rem_next[j] = diff[D_W-1:0];
                    quo_next[j] = {quo_p[j][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j] = trial[D_W-1:0];
                    quo_next[j] = {quo_p[j][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                dv_reg[k]   <= dv_p;
                side_reg[k] <= side_p;
                for (int j = 0; j < LANES; j++)
                    low_reg[k][j] <= low_p[j] << 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_p;
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

FILE: rtl/core/arrive_steering_accel.sv
// Channel   Direction  Handshake     Payload
// item      in         valid/ready   target_x/y, pos_x/y, vel_x/y (signed Q16.16)
// result    out        valid/ready   accel_x/y, accel_valid, stop_velocity, arriving
// cfg       in         cfg_we        cfg_index selects register, cfg_data value
//
// One transaction enters per cycle unless the pipeline holds. The pipeline
// contains two 32-stage square root pipes and three 31-stage divider pipes.
// Reset clears all valid bits and the registers; weight resets to one.
// The whole pipeline holds while the output register is full and not taken.
// Depends on aa_pkg, aa_if, aa_sqrt_pipe and aa_div_pipe.
module arrive_steering_accel import aa_pkg::*; #(
    parameter int FRAC_BITS = AA_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [AA_IDX_W-1:0] cfg_index,
    input  logic [AA_REG_W-1:0] cfg_data,
    aa_item_if.sink             item,
    aa_result_if.source         result
);

    typedef struct packed {
        logic        big;
        logic        sx;
        logic        sy;
        logic [30:0] mx;
        logic [30:0] my;
        logic [31:0] vx;
        logic [31:0] vy;
    } pt_t;

    typedef struct packed {
        logic accv;
        logic stop;
        logic arr;
    } fl_t;

    typedef struct packed {
        fl_t fl;
        pt_t pt;
    } geo_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] dlen;
        geo_t        geo;
    } spd_side_t;

    typedef struct packed {
        logic dnz;
        geo_t geo;
    } des_side_t;

    typedef struct packed {
        fl_t         fl;
        logic        exn;
        logic        eyn;
        logic [30:0] exs;
        logic [30:0] eys;
    } err_side_t;

    typedef struct packed {
        fl_t  fl;
        logic exn;
        logic eyn;
        logic lnz;
    } acc_side_t;

    function automatic logic [32:0] mag33(input logic [32:0] v);
        mag33 = v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic [61:0] m, input logic neg);
        logic over;
        over = |m[61:31];
        if (neg)
            sat32 = over ? 32'h8000_0000 : (~m[31:0] + 32'd1);
        else
            sat32 = over ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    // Configuration registers
    logic [AA_REG_W-1:0] ar_reg, dr_reg, ms_reg, md_reg, wt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ar_reg <= '0;
            dr_reg <= '0;
            ms_reg <= '0;
            md_reg <= '0;
            wt_reg <= AA_REG_W'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (aa_reg_t'(cfg_index))
                REG_ARRIVE_RADIUS: ar_reg <= cfg_data;
                REG_DEST_RADIUS:   dr_reg <= cfg_data;
                REG_MAX_SPEED:     ms_reg <= cfg_data;
                REG_MAX_DECEL:     md_reg <= cfg_data;
                REG_WEIGHT:        wt_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;

    assign en         = !out_valid_reg || result.ready;
    assign item.ready = en;

    // Front stages: offset, magnitudes, squares, squared distance, zones.
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [32:0] dx1_reg, dy1_reg;
    logic [31:0] vx1_reg, vy1_reg;
    pt_t         pt2_reg, pt3_reg, pt4_reg;
    logic [61:0] sqx3_reg, sqy3_reg, ar2_reg, dr2_reg;
    logic [62:0] s4_reg, s5_reg;
    geo_t        geo5_reg;
    logic [32:0] mxf, myf;
    fl_t         fl_next;

    assign mxf = mag33(dx1_reg);
    assign myf = mag33(dy1_reg);

    always_comb
    begin
        fl_next.accv = !(pt4_reg.big || (s4_reg > {1'b0, ar2_reg}));
        fl_next.stop = fl_next.accv && (s4_reg < {1'b0, dr2_reg});
        fl_next.arr  = fl_next.accv && !fl_next.stop;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= {item.target_x[31], item.target_x} - {item.pos_x[31], item.pos_x};
            dy1_reg <= {item.target_y[31], item.target_y} - {item.pos_y[31], item.pos_y};
            vx1_reg <= item.vel_x;
            vy1_reg <= item.vel_y;

            pt2_reg.big <= (|mxf[32:31]) || (|myf[32:31]);
            pt2_reg.sx  <= dx1_reg[32];
            pt2_reg.sy  <= dy1_reg[32];
            pt2_reg.mx  <= mxf[30:0];
            pt2_reg.my  <= myf[30:0];
            pt2_reg.vx  <= vx1_reg;
            pt2_reg.vy  <= vy1_reg;

            sqx3_reg <= pt2_reg.mx * pt2_reg.mx;
            sqy3_reg <= pt2_reg.my * pt2_reg.my;
            ar2_reg  <= ar_reg * ar_reg;
            dr2_reg  <= dr_reg * dr_reg;
            pt3_reg  <= pt2_reg;

            s4_reg  <= {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
            pt4_reg <= pt3_reg;

            s5_reg      <= s4_reg;
            geo5_reg.fl <= fl_next;
            geo5_reg.pt <= pt4_reg;
        end
    end

    // Distance.
    logic        va;
    logic [31:0] dist_a;
    geo_t        geo_a;

    aa_sqrt_pipe #(.IN_W(64), .SIDE_W($bits(geo_t))) u_sqrt_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v5_reg),
        .in_n     ({1'b0, s5_reg}),
        .in_side  (geo5_reg),
        .out_valid(va),
        .out_root (dist_a),
        .out_side (geo_a)
    );

    // Speed scale.
    logic        v6_reg, v7_reg;
    logic [31:0] dist6_reg, dist7_reg, diff_full;
    logic [30:0] diff6_reg, den6_reg, den7_reg;
    logic        ok6_reg, ok7_reg;
    geo_t        geo6_reg, geo7_reg;
    logic [61:0] num7_reg;
    spd_side_t   sside_in, sside_a;
    logic        vsa;
    logic [0:0][30:0] spd_q;

    assign diff_full = dist_a - {1'b0, dr_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff6_reg <= diff_full[30:0];
            den6_reg  <= ar_reg - dr_reg;
            ok6_reg   <= (ar_reg > dr_reg) && (dist_a >= {1'b0, dr_reg});
            dist6_reg <= dist_a;
            geo6_reg  <= geo_a;

            num7_reg  <= ms_reg * diff6_reg;
            den7_reg  <= den6_reg;
            ok7_reg   <= ok6_reg;
            dist7_reg <= dist6_reg;
            geo7_reg  <= geo6_reg;
        end
    end

    assign sside_in.ok   = ok7_reg;
    assign sside_in.dlen = dist7_reg;
    assign sside_in.geo  = geo7_reg;

    aa_div_pipe #(.LANES(1), .N_W(62), .D_W(31), .Q_W(31),
                  .SIDE_W($bits(spd_side_t))) u_div_speed (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v7_reg),
        .in_dvd   (num7_reg),
        .in_div   (den7_reg),
        .in_side  (sside_in),
        .out_valid(vsa),
        .out_quo  (spd_q),
        .out_side (sside_a)
    );

    // Desired velocity components.
    logic        v8_reg, v9_reg;
    logic [30:0] spd8_reg;
    logic [31:0] dist8_reg, dist9_reg;
    geo_t        geo8_reg;
    logic [61:0] nx9_reg, ny9_reg;
    des_side_t   dside9_reg, dside_b;
    logic        vdb;
    logic [1:0][30:0] qxy_b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spd8_reg  <= sside_a.ok ? spd_q[0] : '0;
            dist8_reg <= sside_a.dlen;
            geo8_reg  <= sside_a.geo;

            nx9_reg        <= geo8_reg.pt.mx * spd8_reg;
            ny9_reg        <= geo8_reg.pt.my * spd8_reg;
            dist9_reg      <= dist8_reg;
            dside9_reg.dnz <= (dist8_reg != '0);
            dside9_reg.geo <= geo8_reg;
        end
    end

    aa_div_pipe #(.LANES(2), .N_W(62), .D_W(32), .Q_W(31),
                  .SIDE_W($bits(des_side_t))) u_div_desired (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v9_reg),
        .in_dvd   ({ny9_reg, nx9_reg}),
        .in_div   (dist9_reg),
        .in_side  (dside9_reg),
        .out_valid(vdb),
        .out_quo  (qxy_b),
        .out_side (dside_b)
    );

    // Velocity error, its magnitude, the range shift and its squared length.
    logic        v10_reg, v11_reg, v12_reg, v13_reg, v14_reg, v15_reg;
    logic [31:0] desx10_reg, desy10_reg, vx10_reg, vy10_reg;
    fl_t         fl10_reg, fl11_reg, fl12_reg, fl13_reg, fl14_reg;
    logic [32:0] ex11_reg, ey11_reg, exm_full, eym_full;
    logic [31:0] exm12_reg, eym12_reg;
    logic        exn12_reg, eyn12_reg, exn13_reg, eyn13_reg, exn14_reg, eyn14_reg;
    logic [30:0] exs13_reg, eys13_reg, exs14_reg, eys14_reg;
    logic [61:0] sqex14_reg, sqey14_reg;
    logic [62:0] se15_reg;
    err_side_t   eside15_reg, eside_b;
    logic [31:0] qx_ext, qy_ext;
    logic        shift_one;

    assign qx_ext    = {1'b0, qxy_b[0]};
    assign qy_ext    = {1'b0, qxy_b[1]};
    assign exm_full  = mag33(ex11_reg);
    assign eym_full  = mag33(ey11_reg);
    assign shift_one = exm12_reg[31] || eym12_reg[31];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dside_b.dnz)
            begin
                desx10_reg <= dside_b.geo.pt.sx ? (32'd0 - qx_ext) : qx_ext;
                desy10_reg <= dside_b.geo.pt.sy ? (32'd0 - qy_ext) : qy_ext;
            end
            else
            begin
                desx10_reg <= '0;
                desy10_reg <= '0;
            end
            vx10_reg <= dside_b.geo.pt.vx;
            vy10_reg <= dside_b.geo.pt.vy;
            fl10_reg <= dside_b.geo.fl;

            ex11_reg <= {desx10_reg[31], desx10_reg} - {vx10_reg[31], vx10_reg};
            ey11_reg <= {desy10_reg[31], desy10_reg} - {vy10_reg[31], vy10_reg};
            fl11_reg <= fl10_reg;

            exm12_reg <= exm_full[31:0];
            eym12_reg <= eym_full[31:0];
            exn12_reg <= ex11_reg[32];
            eyn12_reg <= ey11_reg[32];
            fl12_reg  <= fl11_reg;

            exs13_reg <= shift_one ? exm12_reg[31:1] : exm12_reg[30:0];
            eys13_reg <= shift_one ? eym12_reg[31:1] : eym12_reg[30:0];
            exn13_reg <= exn12_reg;
            eyn13_reg <= eyn12_reg;
            fl13_reg  <= fl12_reg;

            sqex14_reg <= exs13_reg * exs13_reg;
            sqey14_reg <= eys13_reg * eys13_reg;
            exs14_reg  <= exs13_reg;
            eys14_reg  <= eys13_reg;
            exn14_reg  <= exn13_reg;
            eyn14_reg  <= eyn13_reg;
            fl14_reg   <= fl13_reg;

            se15_reg        <= {1'b0, sqex14_reg} + {1'b0, sqey14_reg};
            eside15_reg.fl  <= fl14_reg;
            eside15_reg.exn <= exn14_reg;
            eside15_reg.eyn <= eyn14_reg;
            eside15_reg.exs <= exs14_reg;
            eside15_reg.eys <= eys14_reg;
        end
    end

    logic        vlb;
    logic [31:0] len_b;

    aa_sqrt_pipe #(.IN_W(64), .SIDE_W($bits(err_side_t))) u_sqrt_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v15_reg),
        .in_n     ({1'b0, se15_reg}),
        .in_side  (eside15_reg),
        .out_valid(vlb),
        .out_root (len_b),
        .out_side (eside_b)
    );

    // Acceleration direction scaled by max_decel.
    logic        v16_reg, v17_reg;
    logic [61:0] ax16_reg, ay16_reg;
    logic [31:0] len16_reg;
    acc_side_t   aside16_reg, aside_c, aside17_reg;
    logic        vac;
    logic [1:0][30:0] qa_c;
    logic [61:0] px17_reg, py17_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax16_reg        <= eside_b.exs * md_reg;
            ay16_reg        <= eside_b.eys * md_reg;
            len16_reg       <= len_b;
            aside16_reg.fl  <= eside_b.fl;
            aside16_reg.exn <= eside_b.exn;
            aside16_reg.eyn <= eside_b.eyn;
            aside16_reg.lnz <= (len_b != '0);
        end
    end

    aa_div_pipe #(.LANES(2), .N_W(62), .D_W(32), .Q_W(31),
                  .SIDE_W($bits(acc_side_t))) u_div_accel (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v16_reg),
        .in_dvd   ({ay16_reg, ax16_reg}),
        .in_div   (len16_reg),
        .in_side  (aside16_reg),
        .out_valid(vac),
        .out_quo  (qa_c),
        .out_side (aside_c)
    );

    // Weight, then saturation into the output register.
    logic [31:0] accel_x_reg, accel_y_reg;
    logic        accel_valid_reg, stop_velocity_reg, arriving_reg;
    logic [61:0] pxs, pys;
    logic        write_accel;

    assign pxs         = px17_reg >> FRAC_BITS;
    assign pys         = py17_reg >> FRAC_BITS;
    assign write_accel = aside17_reg.fl.arr && aside17_reg.lnz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px17_reg    <= qa_c[0] * wt_reg;
            py17_reg    <= qa_c[1] * wt_reg;
            aside17_reg <= aside_c;

            accel_x_reg       <= write_accel ? sat32(pxs, aside17_reg.exn) : '0;
            accel_y_reg       <= write_accel ? sat32(pys, aside17_reg.eyn) : '0;
            accel_valid_reg   <= aside17_reg.fl.accv;
            stop_velocity_reg <= aside17_reg.fl.stop;
            arriving_reg      <= aside17_reg.fl.arr;
        end
    end

    // Valid bits of the stages held in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            v13_reg       <= 1'b0;
            v14_reg       <= 1'b0;
            v15_reg       <= 1'b0;
            v16_reg       <= 1'b0;
            v17_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= item.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= va;
            v7_reg        <= v6_reg;
            v8_reg        <= vsa;
            v9_reg        <= v8_reg;
            v10_reg       <= vdb;
            v11_reg       <= v10_reg;
            v12_reg       <= v11_reg;
            v13_reg       <= v12_reg;
            v14_reg       <= v13_reg;
            v15_reg       <= v14_reg;
            v16_reg       <= vlb;
            v17_reg       <= vac;
            out_valid_reg <= v17_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.accel_x       = accel_x_reg;
    assign result.accel_y       = accel_y_reg;
    assign result.accel_valid   = accel_valid_reg;
    assign result.stop_velocity = stop_velocity_reg;
    assign result.arriving      = arriving_reg;

endmodule

FILE: test/arrive_steering_accel_tb.sv
// Self-checking testbench for the arrive steering accelerator.
// Drives item transactions with random idling, predicts each result in SystemVerilog
// and compares it field by field. Depends on aa_pkg, aa_if and arrive_steering_accel.
module testbench;
    import aa_pkg::*;

    localparam int FB = AA_FRAC_BITS;
    localparam int LATENCY = 175;
    localparam logic [63:0] LIM31 = 64'h8000_0000;
    localparam logic [63:0] MASK31 = 64'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic               acc_ok;
        logic               stop;
        logic               arr;
    } accel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [AA_IDX_W-1:0] cfg_index;
    logic [AA_REG_W-1:0] cfg_data;

    aa_item_if   item ();
    aa_result_if result ();

    arrive_steering_accel dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .item(item.sink), .result(result.source)
    );

    logic [63:0] r_arrive, r_dest, r_speed, r_decel, r_weight;
    accel_t expected_accels[$];
    int errors;
    bit idle_src, idle_snk;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 4000000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_sign(logic [63:0] m, bit neg);
        if (neg)
            return (m >= LIM31) ? 32'h8000_0000 : 32'(-m);
        return (m > MASK31) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic accel_t arrive_accel(logic signed [31:0] tx, logic signed [31:0] ty,
                                            logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] vx, logic signed [31:0] vy);
        accel_t o;
        logic signed [63:0] dx, dy, desx, desy, ex, ey;
        logic [63:0] mx, my, s, dlen, spd, qx, qy, exm, eym, len, ax, ay;
        o = '0;
        dx = 64'(tx) - 64'(px);
        dy = 64'(ty) - 64'(py);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        if (mx >= LIM31 || my >= LIM31) return o;
        s = mx * mx + my * my;
        if (s > r_arrive * r_arrive) return o;
        o.acc_ok = 1'b1;
        if (s < r_dest * r_dest)
        begin
            o.stop = 1'b1;
            return o;
        end
        o.arr = 1'b1;
        dlen = root64(s);
        spd = 0;
        desx = 0;
        desy = 0;
        if (r_arrive > r_dest && dlen >= r_dest)
            spd = r_speed * (dlen - r_dest) / (r_arrive - r_dest);
        if (dlen != 0)
        begin
            qx = mx * spd / dlen;
            qy = my * spd / dlen;
            desx = dx < 0 ? -$signed(qx) : $signed(qx);
            desy = dy < 0 ? -$signed(qy) : $signed(qy);
        end
        ex = desx - 64'(vx);
        ey = desy - 64'(vy);
        if (ex == 0 && ey == 0) return o;
        exm = ex < 0 ? -ex : ex;
        eym = ey < 0 ? -ey : ey;
        while (exm >= LIM31 || eym >= LIM31)
        begin
            exm = exm >> 1;
            eym = eym >> 1;
        end
        len = root64(exm * exm + eym * eym);
        if (len == 0) return o;
        ax = ((exm * r_decel / len) * r_weight) >> FB;
        ay = ((eym * r_decel / len) * r_weight) >> FB;
        o.ax = sat_sign(ax, ex < 0);
        o.ay = sat_sign(ay, ey < 0);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // Result side: sample at the rising edge, change ready at the falling edge.
    initial
    begin : result_checker
        accel_t e;
        int gap;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_snk && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 5);
                result.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result.ready = 1'b1;
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                if (expected_accels.size() == 0)
                begin
                    $display("%0t: result transaction with no expectation", $realtime);
                    errors++;
                end
                else
                begin
                    e = expected_accels.pop_front();
                    if (result.accel_x !== e.ax) report_mismatch("accel_x", result.accel_x, e.ax);
                    if (result.accel_y !== e.ay) report_mismatch("accel_y", result.accel_y, e.ay);
                    if (result.accel_valid !== e.acc_ok)
                        report_mismatch("accel_valid", 32'(result.accel_valid), 32'(e.acc_ok));
                    if (result.stop_velocity !== e.stop)
                        report_mismatch("stop_velocity", 32'(result.stop_velocity),
                                        32'(e.stop));
                    if (result.arriving !== e.arr)
                        report_mismatch("arriving", 32'(result.arriving), 32'(e.arr));
                end
            end
        end
    end

    task automatic send_item(logic [31:0] tx, logic [31:0] ty, logic [31:0] px,
                             logic [31:0] py, logic [31:0] vx, logic [31:0] vy);
        int gap;
        if (idle_src && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            item.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.valid = 1'b1;
        item.target_x = tx;
        item.target_y = ty;
        item.pos_x = px;
        item.pos_y = py;
        item.vel_x = vx;
        item.vel_y = vy;
        do @(posedge clk); while (!item.ready);
        expected_accels.push_back(arrive_accel(tx, ty, px, py, vx, vy));
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        int guard;
        item.valid = 1'b0;
        guard = 0;
        while (expected_accels.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_reg(aa_reg_t idx, logic [30:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_ARRIVE_RADIUS: r_arrive = 64'(value);
            REG_DEST_RADIUS:   r_dest = 64'(value);
            REG_MAX_SPEED:     r_speed = 64'(value);
            REG_MAX_DECEL:     r_decel = 64'(value);
            REG_WEIGHT:        r_weight = 64'(value);
            default: ;
        endcase
    endtask

    task automatic set_radii(logic [30:0] ar, logic [30:0] dr, logic [30:0] sp,
                             logic [30:0] dc, logic [30:0] w);
        write_reg(REG_ARRIVE_RADIUS, ar);
        write_reg(REG_DEST_RADIUS, dr);
        write_reg(REG_MAX_SPEED, sp);
        write_reg(REG_MAX_DECEL, dc);
        write_reg(REG_WEIGHT, w);
    endtask

    task automatic test_reset_values();
        send_item(0, 0, 0, 0, 0, 0);
        send_item(32'h10000, 0, 0, 0, 0, 0);
        drain_pipeline();
    endtask

    task automatic test_directed_zones();
        set_radii(31'd10 << 16, 31'd2 << 16, 31'd5 << 16, 31'd3 << 16, 31'd1 << 16);
        send_item(0, 0, 0, 0, 0, 0);                         // zero offset, in stop zone
        send_item(32'h10000, 0, 0, 0, 0, 0);                 // stop zone
        send_item(32'h50000, 32'h30000, 0, 0, 0, 0);         // slowdown zone
        send_item(32'h50000, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000); // wide difference
        send_item(32'h20000, 0, 0, 0, 0, 0);                 // exactly on the stop radius
        send_item(32'hA0000, 0, 0, 0, 0, 0);                 // exactly on the arrive radius
        send_item(32'hA0001, 0, 0, 0, 0, 0);                 // just outside
        send_item(32'h7FFFFFFF, 0, 32'h80000000, 0, 0, 0);   // large offset
        send_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0);
        drain_pipeline();
        // The zero difference case: velocity equals the desired velocity.
        set_radii(31'd10 << 16, 31'd0, 31'd0, 31'd3 << 16, 31'd1 << 16);
        send_item(32'h50000, 0, 0, 0, 0, 0);
        drain_pipeline();
        // Equal radii, then dest beyond arrive, then the register extremes.
        set_radii(31'd4 << 16, 31'd4 << 16, 31'd9 << 16, 31'd1 << 16, 31'd1 << 16);
        send_item(32'h40000, 0, 0, 0, 32'h1234, 32'hFFFF0000);
        drain_pipeline();
        set_radii(31'd3 << 16, 31'd6 << 16, 31'd9 << 16, 31'd1 << 16, 31'd1 << 16);
        send_item(32'h40000, 0, 0, 0, 0, 0);
        drain_pipeline();
        set_radii(31'h7FFFFFFF, 31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 32'h80000000, 32'h7FFFFFFF);
        send_item(32'h80000001, 32'h00000000, 0, 0, 32'hFFFFFFFF, 32'h00000001);
        send_item(32'h12345678, 32'hEDCBA987, 32'h00010000, 32'hFFFF0000, 0, 0);
        drain_pipeline();
    endtask

    task automatic random_phase(int count, bit with_idling);
        logic [31:0] px, py, off_x, off_y, vx, vy;
        int k;
        logic [31:0] span;
        idle_src = with_idling;
        idle_snk = with_idling;
        for (int i = 0; i < count; i++)
        begin
            px = $urandom;
            py = $urandom;
            k = $urandom_range(0, 9);
            // Mostly offsets near the zone radii, sometimes anything at all.
            span = (k < 8) ? (r_arrive[31:0] + (r_arrive[31:0] >> 2) + 32'd16) : 32'hFFFFFFFF;
            if (span[31] || span == 0) span = 32'h7FFFFFFF;
            off_x = $urandom_range(0, span) - (span >> 1);
            off_y = $urandom_range(0, span) - (span >> 1);
            if (k >= 8)
            begin
                off_x = $urandom;
                off_y = $urandom;
            end
            vx = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 12);
            vy = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 12);
            send_item(px + off_x, py + off_y, px, py, vx, vy);
        end
        drain_pipeline();
    endtask

    task automatic test_random_settings();
        set_radii(31'd20 << 16, 31'd5 << 16, 31'd8 << 16, 31'd2 << 16, 31'd1 << 16);
        random_phase(150, 1'b1);
        set_radii(31'd1000 << 16, 31'd100 << 16, 31'd400 << 16, 31'd50 << 16, 31'h18000);
        random_phase(150, 1'b1);
        set_radii(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
                  31'($urandom));
        random_phase(100, 1'b1);
        set_radii(31'h7FFFFFFF, 31'h10000, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        random_phase(100, 1'b1);
        set_radii(31'd300, 31'd0, 31'd0, 31'd7, 31'd0);
        random_phase(50, 1'b1);
        set_radii(31'd50 << 16, 31'd10 << 16, 31'd30 << 16, 31'd4 << 16, 31'd1 << 16);
        random_phase(100, 1'b0);
    endtask

    initial
    begin
        errors = 0;
        idle_src = 1'b1;
        idle_snk = 1'b1;
        r_arrive = 0;
        r_dest = 0;
        r_speed = 0;
        r_decel = 0;
        r_weight = 64'd1 << FB;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ARRIVE_RADIUS;
        cfg_data = '0;
        item.valid = 1'b0;
        item.target_x = '0;
        item.target_y = '0;
        item.pos_x = '0;
        item.pos_y = '0;
        item.vel_x = '0;
        item.vel_y = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_values();
        test_directed_zones();
        test_random_settings();
        if (expected_accels.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_accels.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: arrive_steering_accel.f
rtl/core/aa_pkg.sv
rtl/core/aa_if.sv
rtl/core/aa_sqrt_pipe.sv
rtl/core/aa_div_pipe.sv
rtl/core/arrive_steering_accel.sv
test/arrive_steering_accel_tb.sv
